FILE: design/bpq_pkg.sv
// bucket priority queue: shared types, codes and default constants
// used by bpq_alu, bpq_ctrl and bucket_priority_queue; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

    localparam int NODES_DEF   = 256;
    localparam int MAX_KEY_DEF = 63;

    localparam int KEY_W    = 6;
    localparam int NODE_W   = 8;
    localparam int OKEY_W   = 7;
    localparam int COUNT_W  = 9;

    localparam logic [KEY_W-1:0] KEY_LIMIT_RST = 6'd63;

    typedef enum logic [1:0] {
        CMD_INSERT     = 2'd0,
        CMD_DECREASE   = 2'd1,
        CMD_DELETE_MIN = 2'd2,
        CMD_QUERY      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_ABSENT      = 3'd2,
        ST_PRESENT     = 3'd3,
        ST_ABOVE_LIMIT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ALU_INC    = 2'd0,
        ALU_DEC    = 2'd1,
        ALU_SUBSAT = 2'd2
    } alu_op_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  amount;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [NODE_W-1:0]  out_node;
        logic [OKEY_W-1:0]  out_key;
        logic               is_present;
        logic [OKEY_W-1:0]  min_key;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

`default_nettype wire

FILE: design/bpq_alu.sv
// bucket priority queue: shared increment / decrement / saturating subtract
// used by bpq_ctrl for bucket lengths, key decrease and the minimum walk; uses bpq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpq_alu #(
    parameter int W = 10
) (
    input  var bpq_pkg::alu_op_t op,
    input  var logic [W-1:0]     a,
    input  var logic [W-1:0]     b,
    output logic [W-1:0]         y
);

    logic [W:0] diff;

    assign diff = {1'b0, a} - {1'b0, b};

    always_comb
    begin
        case (op)
            bpq_pkg::ALU_INC:    y = a + 1'b1;
            bpq_pkg::ALU_DEC:    y = a - 1'b1;
            // key saturates at zero when the amount reaches the key
            bpq_pkg::ALU_SUBSAT: y = diff[W] ? '0 : diff[W-1:0];
            default:             y = a;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/bpq_ctrl.sv
// bucket priority queue: sequencer with node table, bucket lengths and bucket entries
// depends on bpq_pkg and bpq_alu
`timescale 1ns / 1ps
`default_nettype none

module bpq_ctrl #(
    parameter int NODES   = bpq_pkg::NODES_DEF,
    parameter int MAX_KEY = bpq_pkg::MAX_KEY_DEF
) (
    input  var logic                       clk,
    input  var logic                       rst_n,
    input  var logic [bpq_pkg::KEY_W-1:0]  key_limit,
    input  var logic                       start,
    input  var bpq_pkg::req_t              req,
    output logic                           ready,
    output logic                           res_valid,
    output bpq_pkg::rsp_t                  res,
    input  var logic                       res_take
);

    localparam int BUCKETS = MAX_KEY + 1;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int LOW_W   = $clog2(BUCKETS + 1);
    localparam int NID_W   = $clog2(NODES);
    localparam int POS_W   = NID_W;
    localparam int LEN_W   = $clog2(NODES + 1);
    localparam int SLOTS   = BUCKETS * NODES;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int NM_W    = 1 + BKT_W + POS_W;
    localparam int CLR_N   = (NODES > BUCKETS) ? NODES : BUCKETS;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int ALU_W0  = (LEN_W > LOW_W) ? LEN_W : LOW_W;
    localparam int ALU_W   = (ALU_W0 > bpq_pkg::KEY_W) ? ALU_W0 : bpq_pkg::KEY_W;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_LOOK   = 11'b000_0000_0100,
        S_UNLINK = 11'b000_0000_1000,
        S_FETCH  = 11'b000_0001_0000,
        S_MOVE   = 11'b000_0010_0000,
        S_APPEND = 11'b000_0100_0000,
        S_POP    = 11'b000_1000_0000,
        S_WALK   = 11'b001_0000_0000,
        S_WCHK   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    // memories
    logic [NM_W-1:0]   nm_mem [NODES];
    logic [LEN_W-1:0]  lm_mem [BUCKETS];
    logic [NID_W-1:0]  em_mem [SLOTS];

    logic              nm_we;
    logic [NID_W-1:0]  nm_waddr;
    logic [NM_W-1:0]   nm_wdata;
    logic [NID_W-1:0]  nm_raddr;
    logic [NM_W-1:0]   nm_q;

    logic              lm_we;
    logic [BKT_W-1:0]  lm_waddr;
    logic [LEN_W-1:0]  lm_wdata;
    logic [BKT_W-1:0]  lm_raddr;
    logic [LEN_W-1:0]  lm_q;

    logic              em_we;
    logic [BKT_W-1:0]  em_bkt;
    logic [POS_W-1:0]  em_pos;
    logic [SLOT_W-1:0] em_addr;
    logic [NID_W-1:0]  em_wdata;
    logic [NID_W-1:0]  em_q;

    logic              nm_present;
    logic [BKT_W-1:0]  nm_bkt;
    logic [POS_W-1:0]  nm_pos;

    bpq_pkg::alu_op_t  alu_op;
    logic [ALU_W-1:0]  alu_a;
    logic [ALU_W-1:0]  alu_b;
    logic [ALU_W-1:0]  alu_y;

    state_t                      state_reg, state_next;
    bpq_pkg::cmd_t               cmd_reg, cmd_next;
    logic [bpq_pkg::NODE_W-1:0]  node_reg, node_next;
    logic [bpq_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [bpq_pkg::KEY_W-1:0]   amount_reg, amount_next;
    logic [BKT_W-1:0]            b_reg, b_next;
    logic [POS_W-1:0]            p_reg, p_next;
    logic [BKT_W-1:0]            nb_reg, nb_next;
    logic [POS_W-1:0]            last_reg, last_next;
    logic [LOW_W-1:0]            lowest_reg, lowest_next;
    logic [LEN_W-1:0]            count_reg, count_next;
    logic [CLR_W-1:0]            clr_reg, clr_next;
    bpq_pkg::status_t            status_reg, status_next;
    logic [bpq_pkg::NODE_W-1:0]  onode_reg, onode_next;
    logic [bpq_pkg::OKEY_W-1:0]  okey_reg, okey_next;
    logic                        pres_reg, pres_next;

    logic node_ok;

    assign nm_present = nm_q[NM_W-1];
    assign nm_bkt     = nm_q[POS_W +: BKT_W];
    assign nm_pos     = nm_q[POS_W-1:0];
    assign node_ok    = 32'(node_reg) < NODES;
    assign em_addr    = SLOT_W'(em_bkt) * SLOT_W'(NODES) + SLOT_W'(em_pos);

    bpq_alu #(
        .W (ALU_W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        node_next   = node_reg;
        key_next    = key_reg;
        amount_next = amount_reg;
        b_next      = b_reg;
        p_next      = p_reg;
        nb_next     = nb_reg;
        last_next   = last_reg;
        lowest_next = lowest_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        onode_next  = onode_reg;
        okey_next   = okey_reg;
        pres_next   = pres_reg;

        nm_we    = 1'b0;
        nm_waddr = NID_W'(node_reg);
        nm_wdata = '0;
        nm_raddr = NID_W'(node_reg);
        lm_we    = 1'b0;
        lm_waddr = nb_reg;
        lm_wdata = '0;
        lm_raddr = BKT_W'(lowest_reg);
        em_we    = 1'b0;
        em_bkt   = nb_reg;
        em_pos   = POS_W'(lm_q);
        em_wdata = NID_W'(node_reg);
        alu_op   = bpq_pkg::ALU_INC;
        alu_a    = '0;
        alu_b    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // one node entry and one bucket length per cycle, each while its index is in range
                nm_we    = 32'(clr_reg) < NODES;
                nm_waddr = NID_W'(clr_reg);
                lm_we    = 32'(clr_reg) < BUCKETS;
                lm_waddr = BKT_W'(clr_reg);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                nm_raddr = NID_W'(req.node);
                if (start)
                begin
                    cmd_next    = req.cmd;
                    node_next   = req.node;
                    key_next    = req.key;
                    amount_next = req.amount;
                    status_next = bpq_pkg::ST_OK;
                    onode_next  = req.node;
                    okey_next   = '0;
                    pres_next   = 1'b0;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                case (cmd_reg)
                    bpq_pkg::CMD_INSERT:
                    begin
                        if (key_reg > key_limit || 32'(key_reg) > MAX_KEY)
                        begin
                            status_next = bpq_pkg::ST_ABOVE_LIMIT;
                            state_next  = S_DONE;
                        end
                        else if (!node_ok)
                        begin
                            status_next = bpq_pkg::ST_ABSENT;
                            state_next  = S_DONE;
                        end
                        else if (nm_present)
                        begin
                            status_next = bpq_pkg::ST_PRESENT;
                            okey_next   = bpq_pkg::OKEY_W'(nm_bkt);
                            pres_next   = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            nb_next    = BKT_W'(key_reg);
                            lm_raddr   = BKT_W'(key_reg);
                            state_next = S_APPEND;
                        end
                    end
                    bpq_pkg::CMD_DECREASE:
                    begin
                        if (!node_ok || !nm_present)
                        begin
                            status_next = bpq_pkg::ST_ABSENT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            b_next     = nm_bkt;
                            p_next     = nm_pos;
                            lm_raddr   = nm_bkt;
                            alu_op     = bpq_pkg::ALU_SUBSAT;
                            alu_a      = ALU_W'(nm_bkt);
                            alu_b      = ALU_W'(amount_reg);
                            nb_next    = BKT_W'(alu_y);
                            state_next = S_UNLINK;
                        end
                    end
                    bpq_pkg::CMD_DELETE_MIN:
                    begin
                        if (count_reg == '0 || 32'(lowest_reg) > MAX_KEY || lm_q == '0)
                        begin
                            status_next = bpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            b_next     = BKT_W'(lowest_reg);
                            alu_op     = bpq_pkg::ALU_DEC;
                            alu_a      = ALU_W'(lm_q);
                            last_next  = POS_W'(alu_y);
                            lm_we      = 1'b1;
                            lm_waddr   = BKT_W'(lowest_reg);
                            lm_wdata   = LEN_W'(alu_y);
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        if (!node_ok || !nm_present)
                        begin
                            status_next = bpq_pkg::ST_ABSENT;
                        end
                        else
                        begin
                            okey_next = bpq_pkg::OKEY_W'(nm_bkt);
                            pres_next = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                endcase
            end
            S_UNLINK:
            begin
                alu_op     = bpq_pkg::ALU_DEC;
                alu_a      = ALU_W'(lm_q);
                last_next  = POS_W'(alu_y);
                lm_we      = 1'b1;
                lm_waddr   = b_reg;
                lm_wdata   = LEN_W'(alu_y);
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                // read the last entry of the bucket being shortened
                em_bkt = b_reg;
                em_pos = last_reg;
                if (cmd_reg == bpq_pkg::CMD_DELETE_MIN)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // last entry fills the hole left by the decreased node
                em_we      = 1'b1;
                em_bkt     = b_reg;
                em_pos     = p_reg;
                em_wdata   = em_q;
                nm_we      = 1'b1;
                nm_waddr   = em_q;
                nm_wdata   = {1'b1, b_reg, p_reg};
                lm_raddr   = nb_reg;
                state_next = S_APPEND;
            end
            S_APPEND:
            begin
                em_we    = 1'b1;
                em_bkt   = nb_reg;
                em_pos   = POS_W'(lm_q);
                em_wdata = NID_W'(node_reg);
                nm_we    = 1'b1;
                nm_waddr = NID_W'(node_reg);
                nm_wdata = {1'b1, nb_reg, POS_W'(lm_q)};
                alu_op   = bpq_pkg::ALU_INC;
                alu_a    = ALU_W'(lm_q);
                lm_we    = 1'b1;
                lm_waddr = nb_reg;
                lm_wdata = LEN_W'(alu_y);
                if (LOW_W'(nb_reg) < lowest_reg)
                begin
                    lowest_next = LOW_W'(nb_reg);
                end
                if (cmd_reg == bpq_pkg::CMD_INSERT)
                begin
                    count_next = count_reg + 1'b1;
                end
                okey_next  = bpq_pkg::OKEY_W'(nb_reg);
                pres_next  = 1'b1;
                state_next = S_DONE;
            end
            S_POP:
            begin
                nm_we      = 1'b1;
                nm_waddr   = em_q;
                nm_wdata   = '0;
                count_next = count_reg - 1'b1;
                onode_next = bpq_pkg::NODE_W'(em_q);
                okey_next  = bpq_pkg::OKEY_W'(b_reg);
                if (count_reg == LEN_W'(1))
                begin
                    lowest_next = LOW_W'(BUCKETS);
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                lm_raddr = BKT_W'(lowest_reg);
                if (32'(lowest_reg) > MAX_KEY)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (lm_q != '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    alu_op      = bpq_pkg::ALU_INC;
                    alu_a       = ALU_W'(lowest_reg);
                    lowest_next = LOW_W'(alu_y);
                    state_next  = S_WALK;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            nm_mem[nm_waddr] <= nm_wdata;
        end
        nm_q <= nm_mem[nm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            lm_mem[lm_waddr] <= lm_wdata;
        end
        lm_q <= lm_mem[lm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (em_we)
        begin
            em_mem[em_addr] <= em_wdata;
        end
        em_q <= em_mem[em_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            lowest_reg <= LOW_W'(BUCKETS);
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            lowest_reg <= lowest_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        node_reg   <= node_next;
        key_reg    <= key_next;
        amount_reg <= amount_next;
        b_reg      <= b_next;
        p_reg      <= p_next;
        nb_reg     <= nb_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        onode_reg  <= onode_next;
        okey_reg   <= okey_next;
        pres_reg   <= pres_next;
    end

    assign ready     = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;

    always_comb
    begin
        res.status      = status_reg;
        res.out_node    = onode_reg;
        res.out_key     = okey_reg;
        res.is_present  = pres_reg;
        res.min_key     = bpq_pkg::OKEY_W'(lowest_reg);
        res.entry_count = bpq_pkg::COUNT_W'(count_reg);
    end

    // an idle empty queue carries the sentinel minimum
    a_empty_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg == '0) |-> lowest_reg == LOW_W'(BUCKETS))
        else $error("empty queue without sentinel minimum");

    // node count only moves on append or pop
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_APPEND && state_reg != S_POP) |=> $stable(count_reg))
        else $error("node count changed outside append or pop");

    // minimum walk never goes below the popped bucket
    a_walk_upward: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && cmd_reg == bpq_pkg::CMD_DELETE_MIN &&
         status_reg == bpq_pkg::ST_OK) |-> lowest_reg >= LOW_W'(b_reg))
        else $error("minimum below popped bucket");

    a_lowest_range: assert property (@(posedge clk) disable iff (!rst_n)
        lowest_reg <= LOW_W'(BUCKETS))
        else $error("minimum beyond sentinel");

endmodule

`default_nettype wire

FILE: design/bucket_priority_queue.sv
// bucket priority queue top level: key limit register, result register, sequencer
// depends on bpq_pkg and bpq_ctrl
`timescale 1ns / 1ps
`default_nettype none

// Bucket priority queue over node ids with small keys. Commands: insert,
// decrease key, delete minimum and query; every command word gives one
// result word. One command is worked at a time by a sequencer over three
// memories with one write and one read port each (node table, bucket
// lengths, bucket entries), registered read data and one shared
// increment / decrement / subtract unit, so each memory lookup is a step
// of its own. Delete minimum walks over every empty bucket when searching
// the new minimum, unless it takes the last node. A command turned away at
// the first lookup (above limit, already present, absent node, empty queue)
// goes straight to its result. A finished result sits in an output register,
// so the next command is taken while it waits. After reset the block runs
// a clearing pass over max(NODES, MAX_KEY+1) table indices, 256 by default,
// before the first command; key_limit may be written at any time meanwhile.
module bucket_priority_queue #(
    parameter int NODES   = bpq_pkg::NODES_DEF,
    parameter int MAX_KEY = bpq_pkg::MAX_KEY_DEF
) (
    input  var logic                       clk,
    input  var logic                       rst_n,
    input  var logic                       req_valid,
    output logic                           req_stall,
    input  var bpq_pkg::req_t              req_word,
    output logic                           rsp_valid,
    input  var logic                       rsp_stall,
    output bpq_pkg::rsp_t                  rsp_word,
    input  var logic                       cfg_we,
    input  var logic [bpq_pkg::KEY_W-1:0]  cfg_wdata
);

    logic [bpq_pkg::KEY_W-1:0] key_limit_reg;
    logic                      rsp_valid_reg, rsp_valid_next;
    bpq_pkg::rsp_t             rsp_reg;

    logic          ready;
    logic          start;
    logic          res_valid;
    logic          res_take;
    bpq_pkg::rsp_t res;

    assign start    = req_valid && ready;
    // result register is free when empty or drained this cycle
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    bpq_ctrl #(
        .NODES   (NODES),
        .MAX_KEY (MAX_KEY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_limit (key_limit_reg),
        .start     (start),
        .req       (req_word),
        .ready     (ready),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_limit_reg <= bpq_pkg::KEY_LIMIT_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_limit_reg <= cfg_wdata;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign req_stall = !ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

`default_nettype wire

FILE: tb/sv/bpq_checker.sv
// bucket priority queue checker: watches the command, result and key limit ports,
// predicts each result word and compares it field by field; depends on bpq_pkg
`timescale 1ns / 1ps

module bpq_checker
    import bpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_stall,
    input  req_t             req_word,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    input  rsp_t             rsp_word,
    input  logic             cfg_we,
    input  logic [KEY_W-1:0] cfg_wdata,
    output int               errors,
    output int               in_flight,
    output int               checked
);

    // shadow copy of the queue
    logic             held       [0:255];
    logic [5:0]       bucket_of  [0:255];
    logic [7:0]       position   [0:255];
    logic [8:0]       bucket_len [0:63];
    logic [7:0]       entries    [0:63][0:255];
    logic [6:0]       lowest;
    logic [8:0]       held_count;
    logic [KEY_W-1:0] key_limit;

    rsp_t expected_words[$];

    function automatic void file_node(input logic [7:0] n, input logic [5:0] b);
        logic [8:0] p;
        begin
            p = bucket_len[b];
            entries[b][p[7:0]] = n;
            bucket_of[n] = b;
            position[n] = p[7:0];
            bucket_len[b] = p + 9'd1;
            if ({1'b0, b} < lowest)
                lowest = {1'b0, b};
        end
    endfunction

    function automatic rsp_t apply_queue_command(input req_t r);
        rsp_t       o;
        logic [5:0] b;
        logic [5:0] nb;
        logic [7:0] p;
        logic [8:0] last;
        logic [7:0] moved;
        logic [7:0] n;
        begin
            o.status     = ST_OK;
            o.out_node   = r.node;
            o.out_key    = '0;
            o.is_present = 1'b0;
            case (r.cmd)
                CMD_INSERT:
                begin
                    // limit is checked before presence
                    if (r.key > key_limit)
                        o.status = ST_ABOVE_LIMIT;
                    else if (held[r.node])
                    begin
                        o.status     = ST_PRESENT;
                        o.out_key    = {1'b0, bucket_of[r.node]};
                        o.is_present = 1'b1;
                    end
                    else
                    begin
                        file_node(r.node, r.key);
                        held[r.node] = 1'b1;
                        held_count   = held_count + 9'd1;
                        o.out_key    = {1'b0, r.key};
                        o.is_present = 1'b1;
                    end
                end
                CMD_DECREASE:
                begin
                    if (!held[r.node])
                        o.status = ST_ABSENT;
                    else
                    begin
                        b  = bucket_of[r.node];
                        nb = (r.amount >= b) ? 6'd0 : b - r.amount;
                        // swap the bucket's last entry into the vacated slot
                        p     = position[r.node];
                        last  = bucket_len[b] - 9'd1;
                        moved = entries[b][last[7:0]];
                        entries[b][p]   = moved;
                        position[moved] = p;
                        bucket_len[b]   = last;
                        file_node(r.node, nb);
                        o.out_key    = {1'b0, nb};
                        o.is_present = 1'b1;
                    end
                end
                CMD_DELETE_MIN:
                begin
                    if (held_count == 0 || lowest > 7'd63 || bucket_len[lowest[5:0]] == 0)
                        o.status = ST_EMPTY;
                    else
                    begin
                        b    = lowest[5:0];
                        last = bucket_len[b] - 9'd1;
                        n    = entries[b][last[7:0]];
                        bucket_len[b] = last;
                        held[n]       = 1'b0;
                        held_count    = held_count - 9'd1;
                        o.out_node    = n;
                        o.out_key     = {1'b0, b};
                        if (held_count == 0)
                            lowest = 7'd64;
                        else
                            while (lowest <= 7'd63 && bucket_len[lowest[5:0]] == 0)
                                lowest = lowest + 7'd1;
                    end
                end
                default:
                begin
                    if (!held[r.node])
                        o.status = ST_ABSENT;
                    else
                    begin
                        o.out_key    = {1'b0, bucket_of[r.node]};
                        o.is_present = 1'b1;
                    end
                end
            endcase
            o.min_key     = lowest;
            o.entry_count = held_count;
            return o;
        end
    endfunction

    function automatic int field_differs(input string name, input int want, input int got);
        begin
            if (want != got)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return (want != got) ? 1 : 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   bad;
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
                held[i] = 1'b0;
            for (int i = 0; i < 64; i++)
                bucket_len[i] = '0;
            lowest     = 7'd64;
            held_count = '0;
            key_limit  = KEY_LIMIT_RST;
            expected_words.delete();
            in_flight <= 0;
            errors    <= 0;
            checked   <= 0;
        end
        else
        begin
            if (cfg_we)
                key_limit = cfg_wdata;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with no command waiting, actual %p",
                             $time, rsp_word);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    bad  = field_differs("status", int'(want.status), int'(rsp_word.status))
                         + field_differs("out_node", int'(want.out_node),
                                         int'(rsp_word.out_node))
                         + field_differs("out_key", int'(want.out_key),
                                         int'(rsp_word.out_key))
                         + field_differs("is_present", int'(want.is_present),
                                         int'(rsp_word.is_present))
                         + field_differs("min_key", int'(want.min_key),
                                         int'(rsp_word.min_key))
                         + field_differs("entry_count", int'(want.entry_count),
                                         int'(rsp_word.entry_count));
                    if (bad != 0)
                        errors <= errors + 1;
                    checked <= checked + 1;
                end
            end
            if (req_valid && !req_stall)
                expected_words.insert(expected_words.size(), apply_queue_command(req_word));
            in_flight <= in_flight + int'(req_valid && !req_stall)
                                   - int'(rsp_valid && !rsp_stall);
        end
    end

endmodule

FILE: tb/sv/tb_bucket_priority_queue.sv
// bucket priority queue testbench top: clock, reset, command stimulus and verdict
// depends on bpq_pkg, bpq_checker and the bucket_priority_queue design
`timescale 1ns / 1ps

module tb_bucket_priority_queue;
    import bpq_pkg::*;

    // worst delete minimum walks 63 empty buckets
    localparam int TAIL_CYCLES  = 140;
    localparam int LIMIT_CYCLES = 1000000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req_word  = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp_word;
    logic             cfg_we    = 1'b0;
    logic [KEY_W-1:0] cfg_wdata = '0;

    int errors;
    int in_flight;
    int checked;
    int sent          = 0;
    int cycles        = 0;
    int send_gap_pct  = 0;
    int rsp_stall_pct = 30;
    int mid_limit;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bucket_priority_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bpq_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .in_flight (in_flight),
        .checked   (checked)
    );

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles, in_flight);
            $display("tb_bucket_priority_queue: FAIL");
            $finish;
        end
    end

    // returns at the edge where the word was accepted, valid still high
    task automatic send_word(input req_t w);
        begin
            while ($urandom_range(0, 99) < send_gap_pct)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
            req_valid <= 1'b1;
            req_word  <= w;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            sent++;
        end
    endtask

    task automatic send_cmd(input cmd_t c, input logic [7:0] n,
                            input logic [5:0] k, input logic [5:0] a);
        req_t w;
        begin
            w.cmd    = c;
            w.node   = n;
            w.key    = k;
            w.amount = a;
            send_word(w);
        end
    endtask

    task automatic drain;
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while (in_flight != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_limit(input logic [KEY_W-1:0] v);
        begin
            cfg_we    <= 1'b1;
            cfg_wdata <= v;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    task automatic run_random(input int count, input int insert_pct,
                              input int delete_pct, input int node_top);
        req_t w;
        int   roll;
        begin
            for (int i = 0; i < count; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < insert_pct)
                    w.cmd = CMD_INSERT;
                else if (roll < insert_pct + delete_pct)
                    w.cmd = CMD_DELETE_MIN;
                else if (roll[0])
                    w.cmd = CMD_DECREASE;
                else
                    w.cmd = CMD_QUERY;
                // mostly a narrow node range so commands hit held nodes
                if ($urandom_range(0, 3) == 0)
                    w.node = 8'($urandom_range(0, 255));
                else
                    w.node = 8'($urandom_range(0, node_top));
                w.key = 6'($urandom_range(0, 63));
                if ($urandom_range(0, 1) == 1)
                    w.amount = 6'($urandom_range(0, 7));
                else
                    w.amount = 6'($urandom_range(0, 63));
                send_word(w);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // written during the clearing pass
        write_limit(6'd63);

        send_cmd(CMD_DELETE_MIN, 8'hA5, 6'd0, 6'd0);
        send_cmd(CMD_QUERY, 8'h00, 6'd0, 6'd0);
        send_cmd(CMD_DECREASE, 8'hFF, 6'd0, 6'd63);
        send_cmd(CMD_INSERT, 8'h00, 6'd63, 6'd0);
        send_cmd(CMD_INSERT, 8'hFF, 6'd0, 6'd0);
        send_cmd(CMD_INSERT, 8'h80, 6'd63, 6'd0);
        send_cmd(CMD_INSERT, 8'h00, 6'd5, 6'd0);
        send_cmd(CMD_QUERY, 8'h80, 6'd0, 6'd0);
        send_cmd(CMD_DECREASE, 8'h80, 6'd0, 6'd63);
        send_cmd(CMD_DECREASE, 8'h00, 6'd0, 6'd1);
        send_cmd(CMD_DECREASE, 8'hFF, 6'd0, 6'd0);
        send_cmd(CMD_DELETE_MIN, 8'h00, 6'd0, 6'd0);
        send_cmd(CMD_DELETE_MIN, 8'h00, 6'd0, 6'd0);
        // the one above walks up to bucket 62; this one takes the last node
        send_cmd(CMD_DELETE_MIN, 8'h00, 6'd0, 6'd0);
        send_cmd(CMD_DELETE_MIN, 8'h5A, 6'd0, 6'd0);
        drain();

        write_limit(6'd0);
        send_cmd(CMD_INSERT, 8'h07, 6'd1, 6'd0);
        send_cmd(CMD_INSERT, 8'h07, 6'd63, 6'd0);
        send_cmd(CMD_INSERT, 8'h07, 6'd0, 6'd0);
        send_cmd(CMD_INSERT, 8'h07, 6'd1, 6'd0);
        send_cmd(CMD_QUERY, 8'h07, 6'd0, 6'd0);
        send_cmd(CMD_DELETE_MIN, 8'h07, 6'd0, 6'd0);
        drain();

        // fill phase, receiver mostly stalled
        send_gap_pct  = 15;
        rsp_stall_pct = 80;
        write_limit(6'd63);
        run_random(330, 55, 10, 255);
        drain();

        send_gap_pct  = 80;
        rsp_stall_pct = 15;
        mid_limit     = $urandom_range(1, 62);
        write_limit(6'(mid_limit));
        run_random(330, 35, 25, 63);
        drain();

        send_gap_pct  = 0;
        rsp_stall_pct = 0;
        write_limit(6'd0);
        run_random(120, 30, 30, 31);
        drain();

        // delete heavy, empties the queue and walks buckets
        write_limit(6'd63);
        run_random(220, 20, 50, 255);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("summary: %0d commands sent, %0d result words compared, %0d bad",
                 sent, checked, errors);
        $display("covered: directed corner cases, three pacing phases, key limits 63, 0, %0d",
                 mid_limit);
        if (errors == 0)
            $display("tb_bucket_priority_queue: PASS");
        else
            $display("tb_bucket_priority_queue: FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/bpq_pkg.sv
design/bpq_alu.sv
design/bpq_ctrl.sv
design/bucket_priority_queue.sv
tb/sv/bpq_checker.sv
tb/sv/tb_bucket_priority_queue.sv
